/* sv/pkvbt_pkg.sv */
// Shared types, codes and constants of the paged KV cache block table.
`default_nettype none

package pkvbt_pkg;

    // Parameter defaults
    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int BLOCK_ID_BITS_DEF = 16;

    // Fixed field widths
    localparam int POS_W    = 16;
    localparam int ID_W     = 16;
    localparam int BS_W     = 9;
    localparam int CUR_W    = 17;
    localparam int SLOT_W   = 24;
    localparam int BLKS_W   = 13;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    // Divider: one quotient bit per cycle over the cursor width
    localparam int DIV_STEPS = CUR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [BS_W-1:0]  TPB_RESET     = 9'd16;
    localparam logic [CUR_W-1:0] MAX_LEN_RESET = 17'd4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOKENS_PER_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQ_LEN      = 1'b1;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_ADOPT  = 2'd1,
        FUNC_APPEND = 2'd2,
        FUNC_LOOKUP = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_DECODE_FIRST = 3'd1,
        STAT_UNADOPTED    = 3'd2,
        STAT_FULL         = 3'd3,
        STAT_NOT_FRESH    = 3'd4,
        STAT_TABLE_FULL   = 3'd5,
        STAT_BEYOND       = 3'd6
    } status_t;

    typedef struct packed {
        func_t             func;
        logic              decode_tok;
        logic              prefill_start;
        logic [ID_W-1:0]   block_id;
        logic [POS_W-1:0]  position;
    } cmd_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
        logic [POS_W-1:0]  cursor_now;
        logic [BLKS_W-1:0] blocks_now;
    } res_item_t;

    typedef struct packed {
        logic [CUR_W-1:0] quotient;
        logic [BS_W-1:0]  remainder;
    } div_result_t;

endpackage

`default_nettype wire

/* sv/pkvbt_cmd_if.sv */
// Command channel: one item per transfer into the block table.
`default_nettype none

interface pkvbt_cmd_if;
    logic                 valid;
    logic                 ready;
    pkvbt_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/pkvbt_res_if.sv */
// Result channel: one result per transfer out of the block table.
`default_nettype none

interface pkvbt_res_if;
    logic                 valid;
    logic                 ready;
    pkvbt_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/pkvbt_div.sv */
// Restoring divider: one quotient bit per cycle, position by block size.
`default_nettype none

module pkvbt_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [pkvbt_pkg::CUR_W-1:0]   dividend,
    input  wire logic [pkvbt_pkg::BS_W-1:0]    divisor,
    output logic                               busy,
    output logic                               done,
    output pkvbt_pkg::div_result_t             result
);

    logic [pkvbt_pkg::CUR_W-1:0]     work_reg;
    logic [pkvbt_pkg::BS_W-1:0]      rem_reg;
    logic [pkvbt_pkg::BS_W-1:0]      rem_next;
    logic [pkvbt_pkg::BS_W-1:0]      dsr_reg;
    logic [pkvbt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    logic [pkvbt_pkg::BS_W:0]        trial;
    logic [pkvbt_pkg::BS_W:0]        diff;
    logic                            q_bit;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, work_reg[pkvbt_pkg::CUR_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        q_bit    = (trial >= {1'b0, dsr_reg});
        rem_next = q_bit ? diff[pkvbt_pkg::BS_W-1:0] : trial[pkvbt_pkg::BS_W-1:0];
    end

    // Control: step counter, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pkvbt_pkg::DIV_CNT_W'(pkvbt_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[pkvbt_pkg::CUR_W-2:0], q_bit};
            rem_reg  <= rem_next;
        end
    end

    assign busy             = busy_reg;
    assign done             = done_reg;
    assign result.quotient  = work_reg;
    assign result.remainder = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

/* sv/paged_kv_block_table.sv */
// Top level: paged KV cache block table with token cursor and slot lookup.
//
//  channel   kind         width        role
//  cmd       valid/ready  cmd_item_t   clear, adopt, append, lookup items in
//  res       valid/ready  res_item_t   one result per item out
//  cfg_*     write only   17 bits      tokens_per_block, max_sequence_length
//
// Clear and adopt go from the idle state straight to the finish state.
// Append and lookup pass through the shared bit-serial divider
// (one quotient bit per cycle for the 17-bit cursor), a table read,
// a multiply and the finish state, then the output register.
// One item is in flight at a time.
// Reset clears cursor, block count and flags; the table memory holds
// garbage until written and needs no clearing pass.
// A stalled result sits in the output register while the next item is taken.
`default_nettype none

module paged_kv_block_table
#(
    parameter int TABLE_DEPTH   = pkvbt_pkg::TABLE_DEPTH_DEF,
    parameter int BLOCK_ID_BITS = pkvbt_pkg::BLOCK_ID_BITS_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pkvbt_cmd_if.sink                              cmd,
    pkvbt_res_if.source                            res,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pkvbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pkvbt_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = BLOCK_ID_BITS;
    localparam int CUR_W = pkvbt_pkg::CUR_W;
    localparam int BS_W = pkvbt_pkg::BS_W;
    localparam int SLOT_W = pkvbt_pkg::SLOT_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_RD   = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } seq_state_t;

    seq_state_t                 state_reg;
    seq_state_t                 state_next;
    pkvbt_pkg::cmd_item_t       item_reg;
    logic [CUR_W-1:0]           cursor_reg;
    logic [CUR_W-1:0]           cursor_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       adopted_reg;
    logic                       adopted_next;
    logic                       started_reg;
    logic                       started_next;
    logic [BS_W-1:0]            tpb_reg;
    logic [CUR_W-1:0]           max_len_reg;
    logic [EW-1:0]              rd_data_reg;
    logic [EW+BS_W-1:0]         prod_reg;
    logic [EW+BS_W-1:0]         prod_next;
    logic                       res_valid_reg;
    pkvbt_pkg::res_item_t       res_data_reg;
    pkvbt_pkg::res_item_t       res_c;
    logic [EW-1:0]              table_mem [TABLE_DEPTH];

    logic                       cmd_xfer;
    logic                       fin_go;
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [CUR_W-1:0]           div_dividend;
    pkvbt_pkg::div_result_t     div_res;
    logic [BS_W-1:0]            bs_eff;
    logic [CW-1:0]              count_eff;
    logic                       need_blk;
    logic [EW-1:0]              entry;
    logic [EW-1:0]              id_store;
    logic [CUR_W:0]             sum_adopt;
    logic [CUR_W:0]             sum_one;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;

    // Effective block size: zero acts as one
    assign bs_eff   = (tpb_reg == '0) ? BS_W'(1) : tpb_reg;
    assign id_store = EW'(item_reg.block_id);

    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign fin_go    = (state_reg == ST_FIN) && (!res_valid_reg || res.ready);

    // Start the divider on append and lookup transfers
    assign div_start = cmd_xfer && ((cmd.data.func == pkvbt_pkg::FUNC_APPEND)
                                    || (cmd.data.func == pkvbt_pkg::FUNC_LOOKUP));
    assign div_dividend = (cmd.data.func == pkvbt_pkg::FUNC_LOOKUP)
                          ? CUR_W'(cmd.data.position) : cursor_reg;

    pkvbt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (bs_eff),
        .busy     (div_busy),
        .done     (div_done),
        .result   (div_res)
    );

    // A prefill start on an empty cursor begins a fresh table
    assign count_eff = ((item_reg.func == pkvbt_pkg::FUNC_APPEND) && !item_reg.decode_tok
                        && item_reg.prefill_start && (cursor_reg == '0))
                       ? '0 : count_reg;
    assign need_blk  = (div_res.quotient >= CUR_W'(count_eff));
    assign entry     = need_blk ? id_store : rd_data_reg;
    assign prod_next = entry * bs_eff;
    assign rd_addr   = div_res.quotient[AW-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                    state_next = div_start ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_RD;
            end
            ST_RD:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Finish: checks, result and next state of the cache
    always_comb
    begin
        sum_adopt    = {1'b0, cursor_reg} + (CUR_W+1)'(bs_eff);
        sum_one      = {1'b0, cursor_reg} + (CUR_W+1)'(1);
        cursor_next  = cursor_reg;
        count_next   = count_reg;
        adopted_next = adopted_reg;
        started_next = started_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        res_c.slot   = '0;
        res_c.status = pkvbt_pkg::STAT_OK;
        case (item_reg.func)
            pkvbt_pkg::FUNC_CLEAR:
            begin
                cursor_next  = '0;
                count_next   = '0;
                adopted_next = 1'b0;
                started_next = 1'b0;
            end
            pkvbt_pkg::FUNC_ADOPT:
            begin
                if (started_reg)
                    res_c.status = pkvbt_pkg::STAT_NOT_FRESH;
                else if (sum_adopt >= (CUR_W+1)'(max_len_reg))
                    res_c.status = pkvbt_pkg::STAT_FULL;
                else if (count_reg >= CW'(TABLE_DEPTH))
                    res_c.status = pkvbt_pkg::STAT_TABLE_FULL;
                else
                begin
                    wr_en        = 1'b1;
                    count_next   = count_reg + 1'b1;
                    cursor_next  = sum_adopt[CUR_W-1:0];
                    adopted_next = 1'b1;
                end
            end
            pkvbt_pkg::FUNC_LOOKUP:
            begin
                if ((CUR_W'(item_reg.position) >= cursor_reg)
                    || (div_res.quotient >= CUR_W'(count_reg)))
                    res_c.status = pkvbt_pkg::STAT_BEYOND;
                else
                    res_c.slot = SLOT_W'(prod_reg) + SLOT_W'(div_res.remainder);
            end
            pkvbt_pkg::FUNC_APPEND:
            begin
                wr_addr = count_eff[AW-1:0];
                if (item_reg.decode_tok && !started_reg && !adopted_reg)
                    res_c.status = pkvbt_pkg::STAT_DECODE_FIRST;
                else if (!item_reg.decode_tok && item_reg.prefill_start
                         && (cursor_reg != '0) && !adopted_reg)
                    res_c.status = pkvbt_pkg::STAT_UNADOPTED;
                else if (sum_one >= (CUR_W+1)'(max_len_reg))
                    res_c.status = pkvbt_pkg::STAT_FULL;
                else if (need_blk && (count_eff >= CW'(TABLE_DEPTH)))
                    res_c.status = pkvbt_pkg::STAT_TABLE_FULL;
                else
                begin
                    wr_en        = need_blk;
                    count_next   = count_eff + CW'(need_blk);
                    cursor_next  = sum_one[CUR_W-1:0];
                    started_next = 1'b1;
                    res_c.slot   = SLOT_W'(prod_reg) + SLOT_W'(div_res.remainder);
                end
            end
            default:
            begin
                res_c.status = pkvbt_pkg::STAT_OK;
            end
        endcase
        res_c.cursor_now = cursor_next[pkvbt_pkg::POS_W-1:0];
        res_c.blocks_now = pkvbt_pkg::BLKS_W'(count_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            count_reg     <= '0;
            adopted_reg   <= 1'b0;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            tpb_reg       <= pkvbt_pkg::TPB_RESET;
            max_len_reg   <= pkvbt_pkg::MAX_LEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                cursor_reg    <= cursor_next;
                count_reg     <= count_next;
                adopted_reg   <= adopted_next;
                started_reg   <= started_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pkvbt_pkg::CFG_TOKENS_PER_BLOCK: tpb_reg     <= cfg_data[BS_W-1:0];
                    pkvbt_pkg::CFG_MAX_SEQ_LEN:      max_len_reg <= cfg_data;
                    default:                         tpb_reg     <= tpb_reg;
                endcase
            end
        end
    end

    // Payload registers: item, product, result
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
            item_reg <= cmd.data;
        if (state_reg == ST_MUL)
            prod_reg <= prod_next;
        if (fin_go)
            res_data_reg <= res_c;
    end

    // Block table memory: write at finish, registered read after division
    always_ff @(posedge clk)
    begin
        if (fin_go && wr_en)
            table_mem[wr_addr] <= id_store;
        if (state_reg == ST_RD)
            rd_data_reg <= table_mem[rd_addr];
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish state");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("block count beyond table depth");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide state");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after a transfer");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

endmodule

`default_nettype wire
